### src/mbrx_pkg.sv
// Shared types, register indexes and the CRC-16/MODBUS byte update for the
// Modbus response frame receiver. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mbrx_pkg;

    localparam int BYTE_W = 8;
    localparam int VALUE_W = 16;
    localparam int POS_W = 9;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [7:0] SLAVE_ADDRESS_RESET = 8'h15;
    localparam logic [7:0] FUNCTION_CODE_RESET = 8'h04;
    localparam logic [15:0] VALUE_LIMIT_RESET = 16'd5000;

    localparam logic [CFG_INDEX_W-1:0] REG_SLAVE_ADDRESS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FUNCTION_CODE = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_VALUE_LIMIT = 2'd2;

    typedef struct packed {
        logic [BYTE_W-1:0]  slave_address;
        logic [BYTE_W-1:0]  function_code;
        logic [VALUE_W-1:0] value_limit;
    } mbrx_cfg_t;

    typedef struct packed {
        logic [VALUE_W-1:0] reading;
        logic               clipped;
    } mbrx_result_t;

    function automatic logic [15:0] crc16_update(input logic [15:0] crc_in,
                                                 input logic [7:0] data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

### src/mbrx_frame.sv
// Frame parser: header hunt, byte count, running CRC and saturated reading.
// Advances one byte per step pulse. Depends on mbrx_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mbrx_frame
    import mbrx_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  wire logic [BYTE_W-1:0] data,
    input  wire mbrx_cfg_t         cfg,
    output logic                   res_valid,
    output mbrx_result_t           res
);

    logic [BYTE_W-1:0]  first_byte_reg, first_byte_next;
    logic [15:0]        first_crc_reg, first_crc_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [BYTE_W-1:0]  count_reg, count_next;
    logic [BYTE_W-1:0]  value_high_reg, value_high_next;
    logic [BYTE_W-1:0]  value_low_reg, value_low_next;
    logic [15:0]        crc_reg, crc_next;
    logic [BYTE_W-1:0]  crc_first_reg, crc_first_next;

    logic               header_ok;
    logic [15:0]        crc_src;
    logic [15:0]        crc_step;
    logic [15:0]        crc_fresh;
    logic [POS_W-1:0]   last_pos;
    logic [VALUE_W-1:0] raw;
    logic               crc_ok;

    assign header_ok = (first_byte_reg == cfg.slave_address) && (data == cfg.function_code);
    assign crc_src   = (pos_reg == 9'd1) ? first_crc_reg : crc_reg;
    assign crc_step  = crc16_update(crc_src, data);
    assign crc_fresh = crc16_update(CRC_INIT, data);
    assign last_pos  = {1'b0, count_reg} + 9'd4;
    assign raw       = {value_high_reg, (pos_reg == 9'd4) ? data : value_low_reg};
    assign crc_ok    = (crc_first_reg == crc_reg[7:0]) && (data == crc_reg[15:8]);

    always_comb
    begin
        first_byte_next = first_byte_reg;
        first_crc_next  = first_crc_reg;
        pos_next        = pos_reg;
        count_next      = count_reg;
        value_high_next = value_high_reg;
        value_low_next  = value_low_reg;
        crc_next        = crc_reg;
        crc_first_next  = crc_first_reg;
        res_valid       = 1'b0;
        res.reading     = (raw > cfg.value_limit) ? cfg.value_limit : raw;
        res.clipped     = raw > cfg.value_limit;
        if (step)
        begin
            if (pos_reg == 9'd0)
            begin
                first_byte_next = data;
                first_crc_next  = crc_fresh;
                pos_next        = 9'd1;
            end
            else if (pos_reg == 9'd1)
            begin
                if (header_ok)
                begin
                    crc_next = crc_step;
                    pos_next = 9'd2;
                end
                else
                begin
                    first_byte_next = data;
                    first_crc_next  = crc_fresh;
                end
            end
            else if (pos_reg == 9'd2)
            begin
                count_next = data;
                crc_next   = crc_step;
                pos_next   = 9'd3;
            end
            else if (pos_reg > last_pos)
            begin
                pos_next = 9'd0;
                crc_next = CRC_INIT;
            end
            else
            begin
                if (pos_reg == 9'd3)
                begin
                    value_high_next = data;
                end
                if (pos_reg == 9'd4)
                begin
                    value_low_next = data;
                end
                if (pos_reg == last_pos)
                begin
                    pos_next  = 9'd0;
                    crc_next  = CRC_INIT;
                    res_valid = crc_ok;
                end
                else
                begin
                    if (pos_reg == last_pos - 9'd1)
                    begin
                        crc_first_next = data;
                    end
                    else
                    begin
                        crc_next = crc_step;
                    end
                    pos_next = pos_reg + 9'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_byte_reg <= '0;
            first_crc_reg  <= CRC_INIT;
            pos_reg        <= '0;
            count_reg      <= '0;
            value_high_reg <= '0;
            value_low_reg  <= '0;
            crc_reg        <= CRC_INIT;
            crc_first_reg  <= '0;
        end
        else
        begin
            first_byte_reg <= first_byte_next;
            first_crc_reg  <= first_crc_next;
            pos_reg        <= pos_next;
            count_reg      <= count_next;
            value_high_reg <= value_high_next;
            value_low_reg  <= value_low_next;
            crc_reg        <= crc_next;
            crc_first_reg  <= crc_first_next;
        end
    end

endmodule

`default_nettype wire

### src/modbus_response_frame_receiver.sv
// Top level of the Modbus RTU response receiver: configuration registers,
// input and output registers around the frame parser. Depends on mbrx_pkg, mbrx_frame.
//
// Usage: received serial bytes enter one word at a time on the rx_byte channel
// (in_valid / in_ready). The block hunts for the configured slave address and
// function code, reads the byte count, checks the CRC-16/MODBUS carried low
// byte first at the end of the frame and, on a good frame, sends one word on
// the result channel (out_valid / out_ready): the big-endian value of frame
// bytes 3 and 4, saturated at value_limit, with clipped set when it was cut.
// Bad frames and stray bytes give no word.
// Throughput is one byte per cycle while the result channel is not stalled.
// A frame's last byte passes the input register, its result the result register.
// When the result is not taken, the input register holds its byte and in_ready
// stays high only while that register is free. Configuration must be written
// through cfg_write / cfg_index / cfg_data only while the block is idle; the
// block itself does not enforce this. Reset restores the default registers
// and restarts the header hunt.
`timescale 1ns / 1ps
`default_nettype none

module modbus_response_frame_receiver
    import mbrx_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_write,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [BYTE_W-1:0]      rx_byte,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [VALUE_W-1:0]          reading,
    output logic                        clipped
);

    mbrx_cfg_t         cfg_reg;
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              out_valid_reg;
    mbrx_result_t      out_reg;
    logic              step;
    logic              res_valid;
    mbrx_result_t      res;

    assign step      = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || step;
    assign out_valid = out_valid_reg;
    assign reading   = out_reg.reading;
    assign clipped   = out_reg.clipped;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.slave_address <= SLAVE_ADDRESS_RESET;
            cfg_reg.function_code <= FUNCTION_CODE_RESET;
            cfg_reg.value_limit   <= VALUE_LIMIT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_SLAVE_ADDRESS: cfg_reg.slave_address <= cfg_data[7:0];
                REG_FUNCTION_CODE: cfg_reg.function_code <= cfg_data[7:0];
                REG_VALUE_LIMIT:   cfg_reg.value_limit   <= cfg_data;
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (step && res_valid)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg <= rx_byte;
        end
        if (step && res_valid)
        begin
            out_reg <= res;
        end
    end

    mbrx_frame u_frame (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .data      (in_byte_reg),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res       (res)
    );

`ifndef SYNTHESIS
    a_result_from_step: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(step))
        else $error("result appeared without a processed byte");

    a_clipped_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.clipped |-> out_reg.reading == cfg_reg.value_limit)
        else $error("clipped reading differs from the limit");

    a_unclipped_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_reg.clipped |-> out_reg.reading <= cfg_reg.value_limit)
        else $error("unclipped reading exceeds the limit");

    a_no_step_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |-> !step)
        else $error("byte processed while the result is stalled");
`endif

endmodule

`default_nettype wire

### dv/mbrx_reading_checker.sv
// Checker for the Modbus response frame receiver: follows the configuration
// port and the byte channel, predicts each reading word and compares it with
// the result channel. Depends on mbrx_pkg.
`timescale 1ns / 1ps

module mbrx_reading_checker
    import mbrx_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    input  logic                   in_ready,
    input  logic [BYTE_W-1:0]      rx_byte,
    input  logic                   out_valid,
    input  logic                   out_ready,
    input  logic [VALUE_W-1:0]     reading,
    input  logic                   clipped,
    output int                     mismatch_count,
    output int                     pending_results
);

    mbrx_cfg_t         cfg;
    logic [7:0]        hunt_first;
    logic [POS_W-1:0]  frame_pos;
    logic [7:0]        len_byte;
    logic [7:0]        val_hi;
    logic [7:0]        val_lo;
    logic [7:0]        crc_lo_rx;
    logic [15:0]       crc_acc;
    mbrx_result_t      expected_readings[$];
    mbrx_result_t      exp_word;
    int                errors;

    function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] d);
        logic [15:0] r;
        int i;
        r = c ^ {8'h00, d};
        for (i = 0; i < 8; i++)
        begin
            if (r[0])
                r = (r >> 1) ^ CRC_POLY;
            else
                r = r >> 1;
        end
        return r;
    endfunction

    task automatic take_byte(input logic [7:0] b);
        logic [POS_W-1:0] last;
        logic [15:0] raw;
        mbrx_result_t res;
        last = {1'b0, len_byte} + 9'd4;
        if (frame_pos == 0)
        begin
            hunt_first = b;
            frame_pos = 1;
        end
        else if (frame_pos == 1)
        begin
            if (hunt_first == cfg.slave_address && b == cfg.function_code)
            begin
                crc_acc = crc_byte(crc_byte(CRC_INIT, hunt_first), b);
                frame_pos = 2;
            end
            else
            begin
                hunt_first = b;
            end
        end
        else if (frame_pos == 2)
        begin
            len_byte = b;
            crc_acc = crc_byte(crc_acc, b);
            frame_pos = 3;
        end
        else if (frame_pos > last)
        begin
            frame_pos = 0;
            crc_acc = CRC_INIT;
        end
        else
        begin
            if (frame_pos == 3)
                val_hi = b;
            if (frame_pos == 4)
                val_lo = b;
            if (frame_pos == last)
            begin
                if (crc_lo_rx == crc_acc[7:0] && b == crc_acc[15:8])
                begin
                    raw = {val_hi, val_lo};
                    if (raw > cfg.value_limit)
                    begin
                        res.reading = cfg.value_limit;
                        res.clipped = 1'b1;
                    end
                    else
                    begin
                        res.reading = raw;
                        res.clipped = 1'b0;
                    end
                    expected_readings.push_back(res);
                end
                frame_pos = 0;
                crc_acc = CRC_INIT;
            end
            else
            begin
                if (frame_pos == last - 9'd1)
                    crc_lo_rx = b;
                else
                    crc_acc = crc_byte(crc_acc, b);
                frame_pos = frame_pos + 9'd1;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg = '{SLAVE_ADDRESS_RESET, FUNCTION_CODE_RESET, VALUE_LIMIT_RESET};
            hunt_first = 8'h00;
            frame_pos = '0;
            len_byte = 8'h00;
            val_hi = 8'h00;
            val_lo = 8'h00;
            crc_lo_rx = 8'h00;
            crc_acc = CRC_INIT;
            expected_readings.delete();
            errors = 0;
            mismatch_count <= 0;
            pending_results <= 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_SLAVE_ADDRESS: cfg.slave_address = cfg_data[7:0];
                    REG_FUNCTION_CODE: cfg.function_code = cfg_data[7:0];
                    REG_VALUE_LIMIT:   cfg.value_limit = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                take_byte(rx_byte);
            if (out_valid && out_ready)
            begin
                if (expected_readings.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("ERROR: unexpected word reading=%0d clipped=%0b",
                                 reading, clipped);
                end
                else
                begin
                    exp_word = expected_readings.pop_front();
                    if (reading !== exp_word.reading || clipped !== exp_word.clipped)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display({"ERROR: expected reading=%0d clipped=%0b, ",
                                      "got reading=%0d clipped=%0b"},
                                     exp_word.reading, exp_word.clipped,
                                     reading, clipped);
                    end
                end
            end
            mismatch_count <= errors;
            pending_results <= expected_readings.size();
        end
    end

endmodule

### dv/tb_modbus_response_frame_receiver.sv
// Testbench top for the Modbus response frame receiver: drives framed and
// corrupted byte streams under changing configurations and gives the verdict.
// Depends on mbrx_pkg, modbus_response_frame_receiver and mbrx_reading_checker.
`timescale 1ns / 1ps

module tb_modbus_response_frame_receiver;
    import mbrx_pkg::*;

    localparam int ITEM_TARGET = 1950;
    localparam int PHASES = 6;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

    typedef enum logic [1:0]
    {
        READY_ALWAYS, READY_RANDOM, READY_PATTERN, READY_SPARSE
    } ready_mode_t;
    typedef enum logic [1:0]
    {
        FRAME_GOOD, FRAME_BAD_CRC, FRAME_BAD_BODY, FRAME_TRUNCATED
    } frame_kind_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_ready;
    logic [BYTE_W-1:0]      rx_byte;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [VALUE_W-1:0]     reading;
    logic                   clipped;
    int                     mismatch_count;
    int                     pending_results;

    ready_mode_t ready_mode = READY_ALWAYS;
    int          ready_left = 0;
    logic [15:0] ready_pattern = 16'b1011_0010_0111_0001;
    int          cycles = 0;
    int          burst_left = 0;
    int          bytes_sent = 0;
    mbrx_cfg_t   cur_cfg;

    modbus_response_frame_receiver DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .rx_byte   (rx_byte),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .reading   (reading),
        .clipped   (clipped)
    );

    mbrx_reading_checker u_reading_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .rx_byte         (rx_byte),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .reading         (reading),
        .clipped         (clipped),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (ready_left == 0)
        begin
            ready_mode <= ready_mode_t'($urandom_range(0, 3));
            ready_left <= $urandom_range(20, 300);
        end
        else
        begin
            ready_left <= ready_left - 1;
        end
        case (ready_mode)
            READY_ALWAYS:  out_ready <= 1'b1;
            READY_RANDOM:  out_ready <= ($urandom_range(0, 1) == 1);
            READY_PATTERN: out_ready <= ready_pattern[cycles % 16];
            default:       out_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    function automatic logic [15:0] frame_crc(input logic [7:0] bytes[$]);
        logic [15:0] c;
        int i;
        int k;
        c = 16'hFFFF;
        for (i = 0; i < bytes.size(); i++)
        begin
            c = c ^ {8'h00, bytes[i]};
            for (k = 0; k < 8; k++)
                c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
        end
        return c;
    endfunction

    task automatic push_byte(input logic [7:0] b);
        int gap;
        int r;
        if (burst_left == 0)
        begin
            r = $urandom_range(0, 9);
            if (r < 3)
                gap = 0;
            else if (r < 8)
                gap = $urandom_range(1, 4);
            else if (r < 9)
                gap = $urandom_range(5, 12);
            else
                gap = $urandom_range(20, 40);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        in_valid <= 1'b1;
        rx_byte <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_frame(input logic [7:0] addr, input logic [7:0] fc,
                              input logic [7:0] count, input logic [15:0] raw,
                              input frame_kind_t kind);
        logic [7:0] frame_bytes[$];
        logic [15:0] crc;
        int i;
        int idx;
        int cut;
        frame_bytes = {addr, fc, count};
        if (count >= 1)
            frame_bytes.push_back(raw[15:8]);
        if (count >= 2)
            frame_bytes.push_back(raw[7:0]);
        for (i = 2; i < count; i++)
            frame_bytes.push_back(8'($urandom_range(0, 255)));
        crc = frame_crc(frame_bytes);
        frame_bytes.push_back(crc[7:0]);
        frame_bytes.push_back(crc[15:8]);
        case (kind)
            FRAME_BAD_CRC:
            begin
                idx = frame_bytes.size() - 1 - $urandom_range(0, 1);
                frame_bytes[idx] = frame_bytes[idx] ^ (8'h01 << $urandom_range(0, 7));
            end
            FRAME_BAD_BODY:
            begin
                idx = $urandom_range(2, frame_bytes.size() - 3);
                frame_bytes[idx] = frame_bytes[idx] ^ (8'h01 << $urandom_range(0, 7));
            end
            FRAME_TRUNCATED:
            begin
                cut = $urandom_range(1, frame_bytes.size() - 1);
                while (frame_bytes.size() > cut)
                    void'(frame_bytes.pop_back());
            end
            default: ;
        endcase
        for (i = 0; i < frame_bytes.size(); i++)
            push_byte(frame_bytes[i]);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        burst_left = 0;
        do
            @(posedge clk);
        while (pending_results != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_config(input logic [7:0] sa, input logic [7:0] fc,
                                input logic [15:0] lim, input bit with_spare);
        cfg_write <= 1'b1;
        cfg_index <= REG_SLAVE_ADDRESS;
        cfg_data <= {8'($urandom_range(0, 255)), sa};
        @(posedge clk);
        cfg_index <= REG_FUNCTION_CODE;
        cfg_data <= {8'($urandom_range(0, 255)), fc};
        @(posedge clk);
        cfg_index <= REG_VALUE_LIMIT;
        cfg_data <= lim;
        @(posedge clk);
        if (with_spare)
        begin
            cfg_index <= REG_SPARE;
            cfg_data <= 16'($urandom_range(0, 65535));
            @(posedge clk);
        end
        cfg_write <= 1'b0;
        cur_cfg = '{sa, fc, lim};
    endtask

    function automatic logic [15:0] pick_raw(input logic [15:0] lim);
        case ($urandom_range(0, 6))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return lim;
            3: return lim + 16'd1;
            4: return lim - 16'd1;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [7:0] pick_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 8'($urandom_range(0, 2));
        else if (r < 80)
            return 8'($urandom_range(3, 6));
        else if (r < 97)
            return 8'($urandom_range(7, 20));
        return 8'($urandom_range(100, 255));
    endfunction

    initial
    begin
        int p;
        int r;
        int n;
        int phase_end;
        logic [7:0] sa;
        logic [7:0] fc;
        logic [15:0] lim;
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        rx_byte = '0;
        cur_cfg = '{SLAVE_ADDRESS_RESET, FUNCTION_CODE_RESET, VALUE_LIMIT_RESET};
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_frame(cur_cfg.slave_address, cur_cfg.function_code, 8'd0, 16'h0000, FRAME_GOOD);
        push_byte(cur_cfg.slave_address);
        send_frame(cur_cfg.slave_address, cur_cfg.function_code, 8'd2, 16'hFFFF, FRAME_GOOD);
        send_frame(cur_cfg.slave_address, cur_cfg.function_code, 8'd2, 16'h0000,
                   FRAME_BAD_CRC);
        send_frame(cur_cfg.slave_address, cur_cfg.function_code, 8'd2, cur_cfg.value_limit,
                   FRAME_GOOD);
        drain_results();

        for (p = 0; p < PHASES; p++)
        begin
            case (p)
                0: begin
                       sa = SLAVE_ADDRESS_RESET;
                       fc = FUNCTION_CODE_RESET;
                       lim = VALUE_LIMIT_RESET;
                   end
                1: begin sa = 8'h00; fc = 8'h00; lim = 16'h0000; end
                2: begin sa = 8'hFF; fc = 8'hFF; lim = 16'hFFFF; end
                3: begin sa = 8'hFF; fc = 8'h00; lim = 16'($urandom_range(0, 65535)); end
                4: begin
                       sa = 8'($urandom_range(0, 255));
                       fc = 8'($urandom_range(0, 255));
                       lim = 16'($urandom_range(0, 65535));
                   end
                default: begin sa = 8'h01; fc = 8'h03; lim = 16'h7FFF; end
            endcase
            drain_results();
            write_config(sa, fc, lim, p == 4);
            phase_end = (ITEM_TARGET * (p + 1)) / PHASES;
            while (bytes_sent < phase_end)
            begin
                r = $urandom_range(0, 99);
                if (r < 60)
                    send_frame(cur_cfg.slave_address, cur_cfg.function_code, pick_count(),
                               pick_raw(cur_cfg.value_limit), FRAME_GOOD);
                else if (r < 72)
                    send_frame(cur_cfg.slave_address, cur_cfg.function_code, pick_count(),
                               pick_raw(cur_cfg.value_limit), FRAME_BAD_CRC);
                else if (r < 80)
                    send_frame(cur_cfg.slave_address, cur_cfg.function_code, pick_count(),
                               pick_raw(cur_cfg.value_limit), FRAME_BAD_BODY);
                else if (r < 88)
                    send_frame(cur_cfg.slave_address, cur_cfg.function_code, pick_count(),
                               pick_raw(cur_cfg.value_limit), FRAME_TRUNCATED);
                else if (r < 95)
                begin
                    n = $urandom_range(1, 8);
                    repeat (n)
                    begin
                        if ($urandom_range(0, 3) == 0)
                            push_byte(cur_cfg.slave_address);
                        else
                            push_byte(8'($urandom_range(0, 255)));
                    end
                end
                else
                    send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                               pick_count(), pick_raw(cur_cfg.value_limit), FRAME_GOOD);
                if ($urandom_range(0, 29) == 0)
                    drain_results();
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES * 2) @(posedge clk);
        if (mismatch_count == 0 && pending_results == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
